### sv/icbd_pkg.sv
`default_nettype none

package icbd_pkg;

	localparam int MAX_SYMBOLS_DEF = 128;
	localparam int NUMBER_BITS_DEF = 32;

	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_APPEND  = 2'd1;
	localparam logic [1:0] KIND_CONVERT = 2'd2;

	localparam logic [7:0] LOW_PRINTABLE  = 8'd32;
	localparam logic [7:0] HIGH_PRINTABLE = 8'd126;
	localparam logic [7:0] MINUS_CHAR     = 8'd45;
	localparam logic [7:0] PLUS_CHAR      = 8'd43;
	localparam int         MIN_RADIX      = 2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         symbol;
		logic signed [31:0] number;
	} in_word_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_STK,
		ST_ALPH,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### sv/icbd_ram.sv
`default_nettype none

module icbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### sv/integer_to_custom_base_digits.sv
`default_nettype none

// Converts a signed number to text in a digit alphabet that software loads one
// symbol at a time; the radix is the number of symbols loaded. Clear and append
// words are taken and leave busy low. A convert word raises busy until its last
// character has gone: each digit of a nonzero number is found on the single
// restoring divider (one quotient bit a cycle) and pushed on the digit stack,
// then each character is read from the digit stack and then the alphabet RAM
// and shown, after a leading '-' for a negative number. Characters appear on
// result for one cycle each, marked by strobe, most significant first, with
// last set on the final one; the receiver cannot stall them and must take every
// strobe. A convert with a bad alphabet or fewer than two symbols gives no
// characters and finishes at once.
module integer_to_custom_base_digits
	import icbd_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire in_word_t  request,
	output logic           busy,
	output logic           strobe,
	output out_word_t      result
);

	localparam int DW  = $clog2(MAX_SYMBOLS);
	localparam int CW  = $clog2(MAX_SYMBOLS + 1);
	localparam int SAW = $clog2(NUMBER_BITS);
	localparam int DPW = $clog2(NUMBER_BITS + 1);
	localparam int MW  = NUMBER_BITS + 1;

	state_t state_q, state_d;

	logic [255:0]   seen_q;
	logic [CW-1:0]  count_q;
	logic           bad_q;
	logic [MW-1:0]  mag_q;
	logic [DW-1:0]  rem_q;
	logic [DPW-1:0] step_q;
	logic [DPW-1:0] depth_q;
	logic           neg_q;

	logic                          take;
	logic                          usable;
	logic signed [NUMBER_BITS-1:0] num_v;
	logic signed [MW-1:0]          num_ext;
	logic [MW-1:0]                 mag_in;
	logic                          neg_in;
	logic                          append_bad;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_nx;
	logic [MW-1:0] mag_nx;
	logic          last_step;

	logic           stk_we;
	logic [SAW-1:0] stk_waddr;
	logic [DW-1:0]  stk_wdata;
	logic [DPW-1:0] depth_m1;
	logic [DW-1:0]  stk_rdata;
	logic [7:0]     alph_rdata;
	logic           alph_we;

	assign take   = start && (state_q == ST_IDLE);
	assign usable = !bad_q && (count_q >= CW'(MIN_RADIX));
	assign num_v   = NUMBER_BITS'(request.number);
	assign num_ext = MW'(num_v);
	assign neg_in  = num_v[NUMBER_BITS-1];
	assign mag_in  = neg_in ? MW'(-num_ext) : MW'(num_ext);

	assign append_bad = (request.symbol < LOW_PRINTABLE) || (request.symbol > HIGH_PRINTABLE)
		|| (request.symbol == MINUS_CHAR) || (request.symbol == PLUS_CHAR)
		|| seen_q[request.symbol] || (count_q == CW'(MAX_SYMBOLS));
	assign alph_we = take && (request.kind == KIND_APPEND) && (count_q < CW'(MAX_SYMBOLS));

	// shared restoring divide step
	assign trial     = {rem_q, mag_q[MW-1]};
	assign ge        = trial >= (DW + 1)'(count_q);
	assign diff      = trial - (DW + 1)'(count_q);
	assign rem_nx    = ge ? diff[DW-1:0] : trial[DW-1:0];
	assign mag_nx    = {mag_q[MW-2:0], ge};
	assign last_step = (step_q == DPW'(NUMBER_BITS));

	assign depth_m1 = depth_q - DPW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		busy             = 1'b1;
		strobe           = 1'b0;
		result.character = alph_rdata;
		result.last      = 1'b0;
		stk_we           = 1'b0;
		stk_waddr        = depth_q[SAW-1:0];
		stk_wdata        = rem_nx;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				stk_waddr = '0;
				stk_wdata = '0;
				if (take && (request.kind == KIND_CONVERT) && usable) begin
					if (mag_in == '0) begin
						stk_we  = 1'b1;
						state_d = ST_STK;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (last_step) begin
					stk_we = 1'b1;
					if (mag_nx == '0) begin
						state_d = neg_q ? ST_SIGN : ST_STK;
					end
				end
			end
			ST_SIGN: begin
				strobe           = 1'b1;
				result.character = MINUS_CHAR;
				state_d          = ST_STK;
			end
			ST_STK: begin
				state_d = ST_ALPH;
			end
			ST_ALPH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				strobe      = 1'b1;
				result.last = (depth_q == '0);
				state_d     = (depth_q == '0) ? ST_IDLE : ST_STK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
			step_q  <= '0;
			depth_q <= '0;
		end else begin
			if (take) begin
				unique case (request.kind)
					KIND_CLEAR: begin
						seen_q  <= '0;
						count_q <= '0;
						bad_q   <= 1'b0;
					end
					KIND_APPEND: begin
						seen_q[request.symbol] <= 1'b1;
						if (append_bad) begin
							bad_q <= 1'b1;
						end
						if (alph_we) begin
							count_q <= count_q + CW'(1);
						end
					end
					KIND_CONVERT: begin
						step_q  <= '0;
						depth_q <= (mag_in == '0) ? DPW'(1) : '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_DIV) begin
				if (last_step) begin
					step_q  <= '0;
					depth_q <= depth_q + DPW'(1);
				end else begin
					step_q <= step_q + DPW'(1);
				end
			end
			if (state_q == ST_STK) begin
				depth_q <= depth_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (request.kind == KIND_CONVERT)) begin
			mag_q <= mag_in;
			rem_q <= '0;
			neg_q <= neg_in;
		end else if (state_q == ST_DIV) begin
			mag_q <= mag_nx;
			rem_q <= last_step ? '0 : rem_nx;
		end
	end

	icbd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_SYMBOLS)
	) u_alphabet (
		.clk  (clk),
		.we   (alph_we),
		.waddr(count_q[DW-1:0]),
		.wdata(request.symbol),
		.raddr(stk_rdata),
		.rdata(alph_rdata)
	);

	icbd_ram #(
		.WIDTH(DW),
		.DEPTH(NUMBER_BITS)
	) u_digits (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(depth_m1[SAW-1:0]),
		.rdata(stk_rdata)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("strobe while idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !busy)
		else $error("block still busy after last character");

	a_div_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (count_q >= CW'(MIN_RADIX)) && !bad_q)
		else $error("divide with unusable radix");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DPW'(NUMBER_BITS))
		else $error("digit stack overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SYMBOLS))
		else $error("symbol count past store depth");

endmodule

`default_nettype wire

### dv/digit_text_checker.sv
module digit_text_checker
	import icbd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire in_word_t  request,
	input  wire logic      strobe,
	input  wire out_word_t result,
	output int             fail_count,
	output int             pending
);

	logic [7:0]  alphabet [MAX_SYMBOLS_DEF];
	bit          seen [256];
	int unsigned symbol_count;
	bit          alphabet_bad;
	out_word_t   expected_chars [$];
	out_word_t   want;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void drop_alphabet();
		foreach (seen[i])
			seen[i] = 1'b0;
		symbol_count = 0;
		alphabet_bad = 1'b0;
	endfunction

	function automatic void take_symbol(input logic [7:0] sym);
		if (sym < LOW_PRINTABLE || sym > HIGH_PRINTABLE || sym == MINUS_CHAR
				|| sym == PLUS_CHAR || seen[sym])
			alphabet_bad = 1'b1;
		seen[sym] = 1'b1;
		if (symbol_count >= MAX_SYMBOLS_DEF) begin
			alphabet_bad = 1'b1;
		end else begin
			alphabet[symbol_count] = sym;
			symbol_count++;
		end
	endfunction

	function automatic void predict_characters(input logic [31:0] value);
		logic [32:0] magnitude;
		logic [6:0]  digits [$];
		out_word_t   w;
		if (alphabet_bad || symbol_count < MIN_RADIX)
			return;
		magnitude = value[31] ? 33'd0 - {1'b1, value} : {1'b0, value};
		if (magnitude == 33'd0) begin
			w.character = alphabet[0];
			w.last = 1'b1;
			expected_chars.push_back(w);
			return;
		end
		// most significant digit ends up at the front
		while (magnitude != 33'd0) begin
			digits.push_front(7'(magnitude % symbol_count));
			magnitude = magnitude / symbol_count;
		end
		if (value[31]) begin
			w.character = MINUS_CHAR;
			w.last = 1'b0;
			expected_chars.push_back(w);
		end
		foreach (digits[i]) begin
			w.character = alphabet[digits[i]];
			w.last = (i == digits.size() - 1);
			expected_chars.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_alphabet();
			expected_chars.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (strobe) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %02h last %0b with none expected",
						result.character, result.last));
				end else begin
					want = expected_chars.pop_front();
					if (result.character !== want.character)
						report_mismatch($sformatf("character %02h, expected %02h",
							result.character, want.character));
					if (result.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b on character %02h",
							result.last, want.last, want.character));
				end
			end
			if (start && !busy) begin
				case (request.kind)
					KIND_CLEAR: begin
						drop_alphabet();
					end
					KIND_APPEND: begin
						take_symbol(request.symbol);
					end
					KIND_CONVERT: begin
						predict_characters(request.number);
					end
					default: begin
					end
				endcase
			end
			pending <= expected_chars.size();
		end
	end

endmodule

### dv/tb.sv
module tb;
	import icbd_pkg::*;

	localparam logic [1:0]  KIND_SPARE   = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned RANDOM_WORDS = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	in_word_t    request = '0;
	logic        busy;
	logic        strobe;
	out_word_t   result;
	int          fail_count;
	int          pending;
	int unsigned words_sent = 0;
	int unsigned cycle_count;
	bit          no_gaps = 1'b0;
	logic [7:0]  printable [$];

	integer_to_custom_base_digits uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	digit_text_checker text_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] pick_number(input int unsigned radix);
		logic [63:0] p;
		int unsigned k;
		case ($urandom_range(0, 7))
			0, 1, 2: begin
				return $urandom();
			end
			3: begin
				return $urandom_range(0, 2 * radix * radix);
			end
			4: begin
				return -$urandom_range(1, 2 * radix * radix);
			end
			5: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'd0;
					3: return 32'hffff_ffff;
					default: return 32'd1;
				endcase
			end
			default: begin
				// land next to a power of the radix
				p = 64'd1;
				k = $urandom_range(1, 31);
				while (k != 0 && radix > 1 && p * radix < 64'h8000_0000) begin
					p = p * radix;
					k--;
				end
				p = p + 64'($urandom_range(0, 2)) - 64'd1;
				return $urandom_range(0, 1) ? -p[31:0] : p[31:0];
			end
		endcase
	endfunction

	task automatic issue(input logic [1:0] kind, input logic [7:0] sym, input logic [31:0] value);
		in_word_t    word;
		int unsigned gap;
		word.kind = kind;
		word.symbol = sym;
		word.number = value;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= word;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	task automatic load_alphabet(input int unsigned count);
		logic [7:0]  pool [$];
		logic [7:0]  t;
		int unsigned j;
		pool = printable;
		for (int i = pool.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		issue(KIND_CLEAR, 8'($urandom()), $urandom());
		for (int i = 0; i < count; i++)
			issue(KIND_APPEND, pool[i], $urandom());
	endtask

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned target;
		int unsigned radix;
		logic [7:0]  bad_symbol;
		for (int c = 32; c <= 126; c++)
			if (c != PLUS_CHAR && c != MINUS_CHAR)
				printable.push_back(8'(c));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(KIND_CONVERT, 8'h00, 32'd5);
		issue(KIND_APPEND, "0", 32'hffff_ffff);
		issue(KIND_APPEND, "1", 32'd0);
		issue(KIND_CONVERT, 8'hff, 32'd0);
		issue(KIND_CONVERT, 8'h00, 32'hffff_ffff);
		issue(KIND_CONVERT, 8'h00, 32'h8000_0000);
		issue(KIND_CONVERT, 8'h00, 32'h7fff_ffff);
		issue(KIND_SPARE, 8'h2d, 32'd1);
		issue(KIND_APPEND, "1", 32'd0);
		issue(KIND_CONVERT, 8'h00, 32'd3);
		issue(KIND_CLEAR, 8'hff, 32'hffff_ffff);
		issue(KIND_APPEND, 8'h20, 32'd0);
		issue(KIND_APPEND, 8'h7e, 32'd0);
		issue(KIND_CONVERT, 8'h00, -32'sd5);
		issue(KIND_APPEND, "+", 32'd0);
		issue(KIND_CONVERT, 8'h00, 32'd1);
		issue(KIND_CLEAR, 8'h00, 32'd0);
		issue(KIND_APPEND, "-", 32'd0);
		issue(KIND_APPEND, "a", 32'd0);
		issue(KIND_CONVERT, 8'h00, 32'd1);
		issue(KIND_CLEAR, 8'h00, 32'd0);
		issue(KIND_APPEND, 8'h7f, 32'd0);
		issue(KIND_APPEND, "b", 32'd0);
		issue(KIND_CONVERT, 8'h00, 32'd1);

		// overrun the store, then recover
		issue(KIND_CLEAR, 8'($urandom()), $urandom());
		repeat (MAX_SYMBOLS_DEF + 2)
			issue(KIND_APPEND, 8'($urandom_range(0, 255)), $urandom());
		issue(KIND_CONVERT, 8'($urandom()), $urandom());

		target = words_sent + RANDOM_WORDS;
		radix = 0;
		while (words_sent < target) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 11))
				0, 1, 2, 3, 4, 5: begin
					radix = ($urandom_range(0, 3) == 0) ? $urandom_range(17, printable.size())
						: $urandom_range(2, 16);
					load_alphabet(radix);
					repeat ($urandom_range(2, 6))
						issue(KIND_CONVERT, 8'($urandom()), pick_number(radix));
				end
				6: begin
					radix = ($urandom_range(0, 2) == 0) ? printable.size() : MIN_RADIX;
					load_alphabet(radix);
					repeat ($urandom_range(3, 6))
						issue(KIND_CONVERT, 8'($urandom()), pick_number(radix));
				end
				7, 8: begin
					issue(KIND_APPEND, printable[$urandom_range(0, printable.size() - 1)],
						$urandom());
					radix++;
					repeat ($urandom_range(1, 3))
						issue(KIND_CONVERT, 8'($urandom()), pick_number(radix));
				end
				9, 10: begin
					radix = $urandom_range(0, 8);
					load_alphabet(radix);
					case ($urandom_range(0, 4))
						0: bad_symbol = 8'($urandom_range(0, 31));
						1: bad_symbol = 8'($urandom_range(127, 255));
						2: bad_symbol = $urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR;
						3: bad_symbol = printable[$urandom_range(0, printable.size() - 1)];
						default: bad_symbol = 8'($urandom());
					endcase
					issue(KIND_APPEND, bad_symbol, $urandom());
					repeat ($urandom_range(1, 3))
						issue(KIND_CONVERT, 8'($urandom()), pick_number(radix));
				end
				default: begin
					repeat ($urandom_range(3, 6))
						issue(2'($urandom_range(0, 3)), 8'($urandom()), $urandom());
					issue(KIND_CONVERT, 8'($urandom()), pick_number(radix));
				end
			endcase
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### integer_to_custom_base_digits.f
sv/icbd_pkg.sv
sv/icbd_ram.sv
sv/integer_to_custom_base_digits.sv
dv/digit_text_checker.sv
dv/tb.sv
